// ===== hw/rtl/bnls_pkg.sv =====
package bnls_pkg;

  // Default coordinate width (columns and rows)
  localparam int unsigned COORD_BITS = 12;

  // Distance held by the best-run register before any run has closed
  localparam int NO_DISTANCE = 1000;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LINE_START_COL = 3'd0,
    CFG_LINE_START_ROW = 3'd1,
    CFG_LINE_END_COL   = 3'd2,
    CFG_LINE_END_ROW   = 3'd3,
    CFG_SEARCH_RANGE   = 3'd4,
    CFG_IMAGE_ROWS     = 3'd5
  } cfg_idx_e;

  // Controller to datapath commands
  typedef struct packed {
    logic load_item;  // capture the first pixel of a column
    logic diff;       // form offsets and their magnitudes
    logic mul;        // multiply magnitudes, arm the divider
    logic div_step;   // one quotient bit
    logic calc_exp;   // expected row with sign and clamp
    logic band;       // search band, clear the run tracker
    logic proc;       // process one pixel
    logic sel_live;   // pixel comes from the input port, not the held copy
    logic emit;       // load the result register
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic den_zero;   // end column equals start column
    logic div_last;   // final divider step
    logic held_last;  // held pixel ends its column
    logic out_free;   // result register can take a new result
  } dp_status_t;

endpackage

// ===== hw/rtl/band_run_nearest_line_select_core.sv =====
// Picks, for every image column, the black run nearest to a reference line.
// Input stream: one bilevel pixel per transaction, column by column, rows
// increasing; tlast marks the last pixel of a column. Output stream: one
// transaction per column, carrying the chosen run and its signed distance,
// tuser flagging whether any black run lay inside the search band.
// Configuration: index/data write channel, always ready; write only while no
// column is in progress.
// Timing: the first pixel of a column starts the expected-row interpolation:
// a multiply and a restoring divider giving one quotient bit per cycle. The
// pixel is held while the offsets, product, quotient, expected row and band
// are formed; multiply and divide are skipped when the end columns are equal.
// Every further pixel of the column is processed straight from the input.
// The result appears in the cycle after the column's last pixel is processed:
// at its acceptance, or at the end of interpolation for a one-pixel column.
// The result sits in an output register; while it waits, pixels keep flowing
// and only the next column-ending pixel is held off (tready low).
// Reset clears the controller, the run tracker and the output valid, and
// loads the configuration defaults.
module band_run_nearest_line_select_core #(
  parameter int unsigned CoordBits = bnls_pkg::COORD_BITS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // pixel stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [CB-1:0] pixel_col, [2CB-1:CB] pixel_row, [2CB] is_black, rest zero
  input  logic [((2*CoordBits+8)/8)*8-1:0]    s_axis_tdata,
  input  logic                                s_axis_tlast,   // column_end
  // result stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [CB-1:0] out_col, [2CB-1:CB] run_first_row, [3CB-1:2CB] run_last_row,
  // [4CB:3CB] line_distance, rest zero
  output logic [((4*CoordBits+8)/8)*8-1:0]    m_axis_tdata,
  output logic                                m_axis_tuser,   // found
  // configuration writes
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [bnls_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [CoordBits:0]                  cfg_data_i
);
  import bnls_pkg::*;

  localparam int unsigned OutW = ((4*CoordBits+8)/8)*8;
  localparam int unsigned OutUsed = 4*CoordBits + 1;

  logic [CoordBits-1:0] start_col, start_row, end_col, end_row;
  logic [7:0]           search_range;
  logic [CoordBits:0]   image_rows;
  dp_cmd_t              cmd;
  dp_status_t           status;
  logic [CoordBits-1:0] out_col, out_first, out_last;
  logic [CoordBits:0]   out_dist;

  // Configuration registers
  bnls_cfg_regs #(.CoordBits(CoordBits)) u_cfg (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .line_start_col_o (start_col),
    .line_start_row_o (start_row),
    .line_end_col_o   (end_col),
    .line_end_row_o   (end_row),
    .search_range_o   (search_range),
    .image_rows_o     (image_rows)
  );

  // Sequencer
  bnls_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_last_i  (s_axis_tlast),
    .s_ready_o (s_axis_tready),
    .cmd_o     (cmd),
    .status_i  (status)
  );

  // Interpolation, band and run tracking
  bnls_datapath #(.CoordBits(CoordBits)) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .line_start_col_i (start_col),
    .line_start_row_i (start_row),
    .line_end_col_i   (end_col),
    .line_end_row_i   (end_row),
    .search_range_i   (search_range),
    .image_rows_i     (image_rows),
    .pix_col_i        (s_axis_tdata[CoordBits-1:0]),
    .pix_row_i        (s_axis_tdata[2*CoordBits-1:CoordBits]),
    .pix_black_i      (s_axis_tdata[2*CoordBits]),
    .pix_last_i       (s_axis_tlast),
    .out_valid_o      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .out_col_o        (out_col),
    .out_first_o      (out_first),
    .out_last_o       (out_last),
    .out_dist_o       (out_dist),
    .out_found_o      (m_axis_tuser)
  );

  // Pack the result fields, lowest first
  assign m_axis_tdata = {{(OutW-OutUsed){1'b0}}, out_dist, out_last, out_first, out_col};

endmodule

// ===== hw/rtl/bnls_cfg_regs.sv =====
module bnls_cfg_regs #(
  parameter int unsigned CoordBits = bnls_pkg::COORD_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [bnls_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CoordBits:0]            cfg_data_i,
  output logic [CoordBits-1:0]          line_start_col_o,
  output logic [CoordBits-1:0]          line_start_row_o,
  output logic [CoordBits-1:0]          line_end_col_o,
  output logic [CoordBits-1:0]          line_end_row_o,
  output logic [7:0]                    search_range_o,
  output logic [CoordBits:0]            image_rows_o
);
  import bnls_pkg::*;

  logic [CoordBits-1:0] start_col_q, start_row_q, end_col_q, end_row_q;
  logic [7:0]           range_q;
  logic [CoordBits:0]   rows_q;

  // Writes are always taken
  assign cfg_ready_o = 1'b1;

  // Register file, each value cut to its register width
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_col_q <= '0;
      start_row_q <= '0;
      end_col_q   <= CoordBits'(1);
      end_row_q   <= '0;
      range_q     <= 8'd10;
      rows_q      <= (CoordBits+1)'(2**CoordBits);
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_LINE_START_COL: start_col_q <= cfg_data_i[CoordBits-1:0];
        CFG_LINE_START_ROW: start_row_q <= cfg_data_i[CoordBits-1:0];
        CFG_LINE_END_COL:   end_col_q   <= cfg_data_i[CoordBits-1:0];
        CFG_LINE_END_ROW:   end_row_q   <= cfg_data_i[CoordBits-1:0];
        CFG_SEARCH_RANGE:   range_q     <= cfg_data_i[7:0];
        CFG_IMAGE_ROWS:     rows_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign line_start_col_o = start_col_q;
  assign line_start_row_o = start_row_q;
  assign line_end_col_o   = end_col_q;
  assign line_end_row_o   = end_row_q;
  assign search_range_o   = range_q;
  assign image_rows_o     = rows_q;

endmodule

// ===== hw/rtl/bnls_ctrl.sv =====
module bnls_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_valid_i,
  input  logic                 s_last_i,
  output logic                 s_ready_o,
  output bnls_pkg::dp_cmd_t    cmd_o,
  input  bnls_pkg::dp_status_t status_i
);
  import bnls_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIFF,
    S_MUL,
    S_DIV,
    S_EXP,
    S_BAND,
    S_PIX
  } state_e;

  state_e  state_q, state_d;
  logic    col_open_q, col_open_d;
  dp_cmd_t cmd;
  logic    ready;

  // Next state and datapath commands
  always_comb begin
    state_d    = state_q;
    col_open_d = col_open_q;
    cmd        = '0;
    ready      = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        // a column-ending pixel of an open column needs the result register
        ready = !(col_open_q && s_last_i) || status_i.out_free;
        if (s_valid_i && ready) begin
          if (col_open_q) begin
            cmd.proc     = 1'b1;
            cmd.sel_live = 1'b1;
            cmd.emit     = s_last_i;
            col_open_d   = !s_last_i;
          end else begin
            cmd.load_item = 1'b1;
            state_d       = S_DIFF;
          end
        end
      end
      S_DIFF: begin
        cmd.diff = 1'b1;
        state_d  = status_i.den_zero ? S_EXP : S_MUL;
      end
      S_MUL: begin
        cmd.mul = 1'b1;
        state_d = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = S_EXP;
        end
      end
      S_EXP: begin
        cmd.calc_exp = 1'b1;
        state_d      = S_BAND;
      end
      S_BAND: begin
        cmd.band = 1'b1;
        state_d  = S_PIX;
      end
      S_PIX: begin
        if (!status_i.held_last || status_i.out_free) begin
          cmd.proc   = 1'b1;
          cmd.emit   = status_i.held_last;
          col_open_d = !status_i.held_last;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State and column-open flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      col_open_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      col_open_q <= col_open_d;
    end
  end

  assign cmd_o     = cmd;
  assign s_ready_o = ready;

endmodule

// ===== hw/rtl/bnls_datapath.sv =====
module bnls_datapath #(
  parameter int unsigned CoordBits = bnls_pkg::COORD_BITS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  bnls_pkg::dp_cmd_t      cmd_i,
  output bnls_pkg::dp_status_t   status_o,
  // configuration
  input  logic [CoordBits-1:0]   line_start_col_i,
  input  logic [CoordBits-1:0]   line_start_row_i,
  input  logic [CoordBits-1:0]   line_end_col_i,
  input  logic [CoordBits-1:0]   line_end_row_i,
  input  logic [7:0]             search_range_i,
  input  logic [CoordBits:0]     image_rows_i,
  // pixel from the input port
  input  logic [CoordBits-1:0]   pix_col_i,
  input  logic [CoordBits-1:0]   pix_row_i,
  input  logic                   pix_black_i,
  input  logic                   pix_last_i,
  // result register
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [CoordBits-1:0]   out_col_o,
  output logic [CoordBits-1:0]   out_first_o,
  output logic [CoordBits-1:0]   out_last_o,
  output logic [CoordBits:0]     out_dist_o,
  output logic                   out_found_o
);
  import bnls_pkg::*;

  localparam int unsigned DW   = CoordBits + 1;       // signed offsets
  localparam int unsigned PW   = 2 * CoordBits;       // product / dividend
  localparam int unsigned YW   = 2 * CoordBits + 2;   // signed quotient plus start row
  localparam int unsigned BW   = CoordBits + 3;       // signed rows around the band
  localparam int unsigned LW   = CoordBits + 1;       // reported distance
  localparam int unsigned CntW = $clog2(PW + 1);
  localparam int          YLim = 2 ** (CoordBits + 1);

  localparam logic signed [YW-1:0] YHi      = YW'(YLim);
  localparam logic signed [YW-1:0] YLo      = -YHi;
  localparam logic signed [BW-1:0] CoordMax = BW'(2 ** CoordBits - 1);
  localparam logic signed [BW-1:0] NoDist   = BW'(NO_DISTANCE);
  localparam logic signed [BW-1:0] OneRow   = BW'(1);
  localparam logic [CntW-1:0]      DivSteps = CntW'(PW);

  // held first pixel of a column
  logic [CoordBits-1:0] held_col_q, held_row_q;
  logic                 held_black_q, held_last_q;

  // interpolation
  logic signed [DW-1:0] d_col, d_row, d_den;
  logic [DW-1:0]        abs_col, abs_row, abs_den;
  logic [CoordBits-1:0] mag_a_q, mag_b_q, den_q;
  logic                 neg_q;
  logic [PW-1:0]        quo_q;
  logic [CoordBits-1:0] rem_q;
  logic [CntW-1:0]      cnt_q;
  logic [CoordBits:0]   rem_sh, rem_sub;
  logic                 rem_ge;
  logic                 den_zero;

  // expected row and band
  logic [YW-1:0]        q_ext;
  logic signed [YW-1:0] q_s, y_sum, y_clamp;
  logic signed [BW-1:0] exp_q, band_lo_q, band_hi_q;
  logic signed [BW-1:0] lo_raw, hi_raw, rows_last, hi_img, band_lo_d, band_hi_d;

  // run tracker
  logic                 in_run_q, have_best_q;
  logic [CoordBits-1:0] run_start_q, last_black_q, best_start_q, best_end_q;
  logic signed [BW-1:0] best_dist_q;

  logic [CoordBits-1:0] src_col, src_row;
  logic                 src_black, src_last;
  logic signed [BW-1:0] row_s, ds, de, ads, ade, run_dist;
  logic                 in_band, blk_hit, open_n, close_run, straddle, better;
  logic [CoordBits-1:0] start_n, lastb_n;
  logic                 have_d;
  logic [CoordBits-1:0] best_start_d, best_end_d;
  logic signed [BW-1:0] best_dist_d;

  // result register
  logic                 out_valid_q;
  logic [CoordBits-1:0] out_col_q, out_first_q, out_last_q;
  logic [LW-1:0]        out_dist_q;
  logic                 out_found_q;

  // Offsets of the line, split into sign and magnitude
  assign d_col   = {1'b0, held_col_q} - {1'b0, line_start_col_i};
  assign d_row   = {1'b0, line_end_row_i} - {1'b0, line_start_row_i};
  assign d_den   = {1'b0, line_end_col_i} - {1'b0, line_start_col_i};
  assign abs_col = d_col[DW-1] ? (~d_col + 1'b1) : d_col;
  assign abs_row = d_row[DW-1] ? (~d_row + 1'b1) : d_row;
  assign abs_den = d_den[DW-1] ? (~d_den + 1'b1) : d_den;
  assign den_zero = (line_end_col_i == line_start_col_i);

  // Restoring divider, one quotient bit a step
  assign rem_sh  = {rem_q, quo_q[PW-1]};
  assign rem_ge  = (rem_sh >= {1'b0, den_q});
  assign rem_sub = rem_sh - {1'b0, den_q};

  // Expected row: signed quotient (truncated toward zero) plus start row, clamped
  assign q_ext = {2'b00, quo_q};
  always_comb begin
    if (den_zero) begin
      q_s = '0;
    end else if (neg_q) begin
      q_s = ~q_ext + 1'b1;
    end else begin
      q_s = q_ext;
    end
    y_sum = q_s + YW'(line_start_row_i);
    if (y_sum > YHi) begin
      y_clamp = YHi;
    end else if (y_sum < YLo) begin
      y_clamp = YLo;
    end else begin
      y_clamp = y_sum;
    end
  end

  // Search band clipped to the image
  assign lo_raw    = exp_q - signed'(BW'(search_range_i));
  assign hi_raw    = exp_q + signed'(BW'(search_range_i));
  assign rows_last = signed'(BW'(image_rows_i)) - OneRow;
  assign band_lo_d = lo_raw[BW-1] ? '0 : lo_raw;
  assign hi_img    = (hi_raw < rows_last) ? hi_raw : rows_last;
  assign band_hi_d = (hi_img < CoordMax) ? hi_img : CoordMax;

  // Pixel source
  assign src_col   = cmd_i.sel_live ? pix_col_i   : held_col_q;
  assign src_row   = cmd_i.sel_live ? pix_row_i   : held_row_q;
  assign src_black = cmd_i.sel_live ? pix_black_i : held_black_q;
  assign src_last  = cmd_i.sel_live ? pix_last_i  : held_last_q;

  // Run tracking and the distance of a closing run
  always_comb begin
    row_s     = signed'(BW'(src_row));
    in_band   = (row_s >= band_lo_q) && (row_s <= band_hi_q);
    blk_hit   = in_band && src_black;
    open_n    = in_run_q || blk_hit;
    start_n   = (blk_hit && !in_run_q) ? src_row : run_start_q;
    lastb_n   = blk_hit ? src_row : last_black_q;
    // a white pixel in band ends the run, so does the end of the column
    close_run = (in_run_q && in_band && !src_black) || (src_last && open_n);

    ds  = signed'(BW'(start_n)) - exp_q;
    de  = signed'(BW'(lastb_n)) - exp_q;
    ads = ds[BW-1] ? -ds : ds;
    ade = de[BW-1] ? -de : de;
    straddle = (ds[BW-1] && !de[BW-1] && (de != '0)) ||
               (de[BW-1] && !ds[BW-1] && (ds != '0));
    if (straddle) begin
      run_dist = (ds < de) ? ds : de;
    end else begin
      run_dist = (ads < ade) ? ads : ade;
    end

    // strict compare keeps the first of equally near runs
    better       = close_run && (run_dist < best_dist_q);
    have_d       = have_best_q || better;
    best_dist_d  = better ? run_dist : best_dist_q;
    best_start_d = better ? start_n  : best_start_q;
    best_end_d   = better ? lastb_n  : best_end_q;
  end

  // Held pixel, interpolation and divider registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      held_col_q   <= pix_col_i;
      held_row_q   <= pix_row_i;
      held_black_q <= pix_black_i;
      held_last_q  <= pix_last_i;
    end
    if (cmd_i.diff) begin
      mag_a_q <= abs_col[CoordBits-1:0];
      mag_b_q <= abs_row[CoordBits-1:0];
      den_q   <= abs_den[CoordBits-1:0];
      neg_q   <= d_col[DW-1] ^ d_row[DW-1] ^ d_den[DW-1];
    end
    if (cmd_i.mul) begin
      quo_q <= mag_a_q * mag_b_q;
      rem_q <= '0;
      cnt_q <= DivSteps;
    end else if (cmd_i.div_step) begin
      quo_q <= {quo_q[PW-2:0], rem_ge};
      rem_q <= rem_ge ? rem_sub[CoordBits-1:0] : rem_sh[CoordBits-1:0];
      cnt_q <= cnt_q - 1'b1;
    end
    if (cmd_i.calc_exp) begin
      exp_q <= y_clamp[BW-1:0];
    end
    if (cmd_i.band) begin
      band_lo_q <= band_lo_d;
      band_hi_q <= band_hi_d;
    end
  end

  // Run and best-run payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.band) begin
      best_dist_q  <= NoDist;
      best_start_q <= '0;
      best_end_q   <= '0;
    end else if (cmd_i.proc) begin
      run_start_q  <= start_n;
      last_black_q <= lastb_n;
      best_dist_q  <= best_dist_d;
      best_start_q <= best_start_d;
      best_end_q   <= best_end_d;
    end
  end

  // Run control flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_run_q    <= 1'b0;
      have_best_q <= 1'b0;
    end else if (cmd_i.band) begin
      in_run_q    <= 1'b0;
      have_best_q <= 1'b0;
    end else if (cmd_i.proc) begin
      in_run_q    <= open_n && !close_run;
      have_best_q <= have_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_col_q   <= src_col;
      out_first_q <= have_d ? best_start_d : '0;
      out_last_q  <= have_d ? best_end_d : '0;
      out_dist_q  <= have_d ? best_dist_d[LW-1:0] : '0;
      out_found_q <= have_d;
    end
  end

  assign status_o.den_zero  = den_zero;
  assign status_o.div_last  = (cnt_q == CntW'(1));
  assign status_o.held_last = held_last_q;
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_col_o   = out_col_q;
  assign out_first_o = out_first_q;
  assign out_last_o  = out_last_q;
  assign out_dist_o  = out_dist_q;
  assign out_found_o = out_found_q;

endmodule
